FILE: sv/running_mean_variance_minmax_assert.svh
// Assertion macros shared by the running statistics modules.
`ifndef RUNNING_MEAN_VARIANCE_MINMAX_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_MINMAX_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled in reset
`define RMV_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("running statistics: check failed");
// Next-cycle implication, disabled in reset
`define RMV_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("running statistics: check failed");
`else
`define RMV_ASSERT_IMP(label, clk, rst, pre, post)
`define RMV_ASSERT_NXT(label, clk, rst, pre, post)
`endif
`endif

FILE: sv/rmvm_pkg.sv
// Package: formats, controller states and command/status types.
package rmvm_pkg;

   // Sample and mean formats
   localparam int SAMPLE_WIDTH       = 24;
   localparam int MEAN_FRACTION_BITS = 16;
   localparam int MEAN_W             = SAMPLE_WIDTH + MEAN_FRACTION_BITS;

   // Port field widths
   localparam int SAMPLE_PORT_W = 24;
   localparam int COUNT_W       = 32;
   localparam int MEAN_PORT_W   = 40;
   localparam int VAR_W         = 54;
   localparam int DEV_W         = 64;

   // Serial divider: 64-bit dividend, count-wide divisor
   localparam int DIV_W  = DEV_W;
   localparam int STEP_W = $clog2(DIV_W + 1);

   // Multiplier split into four half-by-half partial products
   localparam int HALF_W = (MEAN_W + 1) / 2;
   localparam int PROD_W = 4 * HALF_W;
   localparam int TERM_W = (PROD_W + 8 > DEV_W + 1) ? PROD_W + 8 : DEV_W + 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MEAN_GO,
      S_MEAN_WAIT,
      S_MEAN_UPD,
      S_DIFF,
      S_MUL,
      S_ACC,
      S_DEV,
      S_VAR_GO,
      S_VAR_WAIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       div_start;
      logic       div_var;
      logic       mean_upd;
      logic       diff;
      logic       mul_step;
      logic       acc_step;
      logic       dev_upd;
      logic       out_load;
      logic [1:0] pp_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
   } dp_stat_type;

endpackage

FILE: sv/rmvm_divider.sv
// Restoring serial divider, one quotient bit per cycle.
module rmvm_divider
   import rmvm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_W-1:0]   dividend,
   input  logic [COUNT_W-1:0] divisor,
   input  logic [STEP_W-1:0]  steps,
   output logic [DIV_W-1:0]   quotient,
   output logic               busy,
   output logic               done
);

   logic               busy_ff, busy_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W-1:0]   dvd_ff, dvd_in;
   logic [DIV_W-1:0]   quot_ff, quot_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] dvs_ff, dvs_in;
   logic [COUNT_W:0]   trial;
   logic               fits;

   // Operand load on start, else one shift-subtract step while busy
   always_comb begin
      trial   = {rem_ff, dvd_ff[DIV_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         dvd_in  = dividend;
         quot_in = '0;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[DIV_W-2:0], 1'b0};
         quot_in = {quot_ff[DIV_W-2:0], fits};
         rem_in  = fits ? COUNT_W'(trial - {1'b0, dvs_ff}) : COUNT_W'(trial);
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign quotient = quot_ff;
   assign busy     = busy_ff;
   assign done     = busy_ff && (cnt_ff == STEP_W'(1));

endmodule

FILE: sv/rmvm_datapath.sv
// Datapath: statistics state, Welford update, partial-product multiplier, result word.
module rmvm_datapath
   import rmvm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_stat_type              stat,
   input  logic [SAMPLE_PORT_W-1:0] req_sample,
   output logic [COUNT_W-1:0]       rsp_event_count,
   output logic [MEAN_PORT_W-1:0]   rsp_running_mean,
   output logic [VAR_W-1:0]         rsp_running_variance,
   output logic [SAMPLE_PORT_W-1:0] rsp_minimum_sample,
   output logic [SAMPLE_PORT_W-1:0] rsp_maximum_sample
);

`include "running_mean_variance_minmax_assert.svh"

   // Statistics state
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [MEAN_W-1:0]       mean_ff, mean_in;
   logic [DEV_W-1:0]        dev_ff, dev_in;
   logic [SAMPLE_WIDTH-1:0] min_ff, min_in;
   logic [SAMPLE_WIDTH-1:0] max_ff, max_in;

   // Per-word working registers
   logic [SAMPLE_WIDTH-1:0] x_ff;
   logic [MEAN_W-1:0]       d1_ff, d1_in;
   logic                    below_ff, below_in;
   logic [MEAN_W-1:0]       d2_ff;
   logic [2*HALF_W-1:0]     pp_ff;
   logic [PROD_W-1:0]       acc_ff, acc_in;

   // Result word
   logic [COUNT_W-1:0]      out_count_ff;
   logic [MEAN_W-1:0]       out_mean_ff;
   logic [VAR_W-1:0]        out_var_ff, var_in;
   logic [SAMPLE_WIDTH-1:0] out_min_ff, out_max_ff;

   logic [SAMPLE_WIDTH-1:0] x_in;
   logic [MEAN_W-1:0]       xs_in, x_scaled, quot_mean, d2_in;
   logic [2*HALF_W-1:0]     a_pad, b_pad;
   logic [HALF_W-1:0]       a_part, b_part;
   logic [PROD_W-1:0]       pp_shift;
   logic [TERM_W-1:0]       term_wide;
   logic [DEV_W-1:0]        term;
   logic [DEV_W:0]          dev_sum;
   logic [DIV_W-1:0]        div_dividend, quotient;
   logic [COUNT_W-1:0]      div_divisor;
   logic [STEP_W-1:0]       div_steps;
   logic [VAR_W-1:0]        var_sat;
   logic                    div_busy, div_done;

   // Incoming sample and first difference from the old mean
   always_comb begin
      x_in     = SAMPLE_WIDTH'(req_sample);
      xs_in    = MEAN_W'(x_in) << MEAN_FRACTION_BITS;
      below_in = xs_in < mean_ff;
      d1_in    = below_in ? mean_ff - xs_in : xs_in - mean_ff;
      x_scaled = MEAN_W'(x_ff) << MEAN_FRACTION_BITS;
   end

   // Mean step and second difference from the new mean
   always_comb begin
      quot_mean = quotient[MEAN_W-1:0];
      mean_in   = below_ff ? mean_ff - quot_mean : mean_ff + quot_mean;
      d2_in     = below_ff ? mean_ff - x_scaled : x_scaled - mean_ff;
   end

   // Divider operands: d1 over the count, or the deviation sum over count less one
   always_comb begin
      if (cmd.div_var) begin
         div_dividend = dev_ff;
         div_divisor  = count_ff - 1'b1;
         div_steps    = STEP_W'(DIV_W);
      end else begin
         div_dividend = DIV_W'(d1_ff) << (DIV_W - MEAN_W);
         div_divisor  = count_ff;
         div_steps    = STEP_W'(MEAN_W);
      end
   end

   rmvm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .quotient (quotient),
      .busy     (div_busy),
      .done     (div_done)
   );

   // Partial product select and accumulation shift
   always_comb begin
      a_pad  = (2*HALF_W)'(d1_ff);
      b_pad  = (2*HALF_W)'(d2_ff);
      a_part = cmd.pp_sel[1] ? a_pad[2*HALF_W-1:HALF_W] : a_pad[HALF_W-1:0];
      b_part = cmd.pp_sel[0] ? b_pad[2*HALF_W-1:HALF_W] : b_pad[HALF_W-1:0];
      unique case (cmd.pp_sel)
         2'd0:    pp_shift = PROD_W'(pp_ff);
         2'd1,
         2'd2:    pp_shift = PROD_W'(pp_ff) << HALF_W;
         default: pp_shift = PROD_W'(pp_ff) << (2*HALF_W);
      endcase
      acc_in = acc_ff + pp_shift;
   end

   // Product to Q.8, then saturating add into the deviation sum
   always_comb begin
      term_wide = (TERM_W'(acc_ff) << 8) >> (2*MEAN_FRACTION_BITS);
      term      = (|term_wide[TERM_W-1:DEV_W]) ? '1 : term_wide[DEV_W-1:0];
      dev_sum   = {1'b0, dev_ff} + {1'b0, term};
      dev_in    = dev_sum[DEV_W] ? '1 : dev_sum[DEV_W-1:0];
   end

   // Count, extremes and variance
   always_comb begin
      count_in = (count_ff == '1) ? count_ff : count_ff + 1'b1;
      min_in   = (x_in < min_ff) ? x_in : min_ff;
      max_in   = (x_in > max_ff) ? x_in : max_ff;
      var_sat  = (|quotient[DIV_W-1:VAR_W]) ? '1 : quotient[VAR_W-1:0];
      var_in   = (count_ff > COUNT_W'(1)) ? var_sat : '0;
   end

   // Statistics state, reset to zero but for the minimum, which resets to all ones
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mean_ff  <= '0;
         dev_ff   <= '0;
         min_ff   <= '1;
         max_ff   <= '0;
      end else begin
         if (cmd.load) begin
            count_ff <= count_in;
            min_ff   <= min_in;
            max_ff   <= max_in;
         end
         if (cmd.mean_upd) begin
            mean_ff <= mean_in;
         end
         if (cmd.dev_upd) begin
            dev_ff <= dev_in;
         end
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff     <= x_in;
         d1_ff    <= d1_in;
         below_ff <= below_in;
         acc_ff   <= '0;
      end else if (cmd.acc_step) begin
         acc_ff <= acc_in;
      end
      if (cmd.diff) begin
         d2_ff <= d2_in;
      end
      if (cmd.mul_step) begin
         pp_ff <= a_part * b_part;
      end
      if (cmd.out_load) begin
         out_count_ff <= count_ff;
         out_mean_ff  <= mean_ff;
         out_var_ff   <= var_in;
         out_min_ff   <= min_ff;
         out_max_ff   <= max_ff;
      end
   end

   assign stat.div_busy        = div_busy;
   assign stat.div_done        = div_done;
   assign rsp_event_count      = out_count_ff;
   assign rsp_running_mean     = MEAN_PORT_W'(out_mean_ff);
   assign rsp_running_variance = out_var_ff;
   assign rsp_minimum_sample   = SAMPLE_PORT_W'(out_min_ff);
   assign rsp_maximum_sample   = SAMPLE_PORT_W'(out_max_ff);

   // The deviation sum only grows, and a counted sample leaves a non-zero count
   `RMV_ASSERT_NXT(a_dev_grows, clock, reset, cmd.dev_upd, dev_ff >= $past(dev_ff))
   `RMV_ASSERT_NXT(a_count_set, clock, reset, cmd.load, count_ff != '0)

endmodule

FILE: sv/rmvm_ctrl.sv
// Controller: sequences one word through divide, multiply and divide, owns the handshakes.
module rmvm_ctrl
   import rmvm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

`include "running_mean_variance_minmax_assert.svh"

   state_type  state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      cmd.pp_sel   = idx_ff;
      req_ready    = 1'b0;
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = S_MEAN_GO;
            end
         end
         S_MEAN_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_MEAN_WAIT;
         end
         S_MEAN_WAIT: begin
            if (stat.div_done) begin
               state_in = S_MEAN_UPD;
            end
         end
         S_MEAN_UPD: begin
            cmd.mean_upd = 1'b1;
            state_in     = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = S_ACC;
         end
         S_ACC: begin
            cmd.acc_step = 1'b1;
            idx_in       = idx_ff + 1'b1;
            state_in     = (idx_ff == 2'd3) ? S_DEV : S_MUL;
         end
         S_DEV: begin
            cmd.dev_upd = 1'b1;
            state_in    = S_VAR_GO;
         end
         S_VAR_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_var   = 1'b1;
            state_in      = S_VAR_WAIT;
         end
         S_VAR_WAIT: begin
            cmd.div_var = 1'b1;
            if (stat.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.div_var = 1'b1;
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Divider started only when free; result word never overwrites one not taken
   `RMV_ASSERT_IMP(a_div_free, clock, reset, cmd.div_start, !stat.div_busy)
   `RMV_ASSERT_IMP(a_out_free, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_ready)
   `RMV_ASSERT_NXT(a_accept_go, clock, reset, req_valid && req_ready, state_ff == S_MEAN_GO)

endmodule

FILE: sv/running_mean_variance_minmax.sv
// One word in flight: a new word is accepted only in idle, after the last result word is loaded.
// Each word passes the serial divider for the mean (40 quotient bits), four partial-product
//   multiply and accumulate steps, and the divider again for the variance (64 quotient bits).
// The next word is accepted while the result word waits in the output register.
// Reset (synchronous, active high) clears count, mean and deviation sum to zero,
//   the minimum to all ones, the maximum to zero, and empties the output register.
module running_mean_variance_minmax
   import rmvm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [SAMPLE_PORT_W-1:0] req_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [COUNT_W-1:0]       rsp_event_count,
   output logic [MEAN_PORT_W-1:0]   rsp_running_mean,
   output logic [VAR_W-1:0]         rsp_running_variance,
   output logic [SAMPLE_PORT_W-1:0] rsp_minimum_sample,
   output logic [SAMPLE_PORT_W-1:0] rsp_maximum_sample
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequencer
   rmvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Arithmetic and state
   rmvm_datapath u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_sample           (req_sample),
      .rsp_event_count      (rsp_event_count),
      .rsp_running_mean     (rsp_running_mean),
      .rsp_running_variance (rsp_running_variance),
      .rsp_minimum_sample   (rsp_minimum_sample),
      .rsp_maximum_sample   (rsp_maximum_sample)
   );

endmodule
